/* src/dps_pkg.sv */
// Shared constants for the dual pool packet scheduler.
`timescale 1ns / 1ps

package dps_pkg;

   localparam int RefreshDepthDefault = 96;
   localparam int RingDepthDefault    = 16;

   localparam int WordW     = 64;
   localparam int DecoderW  = 4;
   localparam int TypeW     = 3;
   localparam int ModeW     = 2;
   localparam int SlotW     = 7;
   localparam int SlotsPerDecoder = 6;

   localparam int ReqDataW = 72;
   localparam int ReqUserW = 5;

   localparam logic [ModeW-1:0] ModeAdd   = 2'd0;
   localparam logic [ModeW-1:0] ModeFill  = 2'd1;
   localparam logic [ModeW-1:0] ModeFetch = 2'd2;

   localparam logic [WordW-1:0] IdlePacketReset = '0;

   typedef enum logic [3:0] {
      StSweep = 4'b0001,
      StIdle  = 4'b0010,
      StPush  = 4'b0100,
      StFetch = 4'b1000
   } state_type;

endpackage

/* src/dps_ram.sv */
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps

module dps_ram #(
   parameter int   DEPTH = 16,
   parameter int   WIDTH = 64,
   localparam int  AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/dual_pool_packet_scheduler_top.sv */
// Top level of the dual pool packet scheduler: sequencer, refresh table and priority ring.
// Add, if the slot is in range: table write and first ring push, then second ring push.
// Fill: one table entry written per cycle through the write port.
// Fetch: memory read at the accepting edge, then result registered from StFetch;
// a stalled output holds the fetch and the input until the result register frees.
// Reset: synchronous; a clearing pass over every table entry loads the table with the
// idle packet before the first item is accepted.
`timescale 1ns / 1ps

module dual_pool_packet_scheduler_top #(
   parameter int REFRESH_DEPTH = dps_pkg::RefreshDepthDefault,
   parameter int RING_DEPTH    = dps_pkg::RingDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dps_pkg::WordW-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // decoder_index [3:0], packet_word [67:4], zero [71:68]
   input  logic [dps_pkg::ReqDataW-1:0]  req_tdata,
   // mode [1:0], packet_type [4:2]
   input  logic [dps_pkg::ReqUserW-1:0]  req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // packet_word_out [63:0]
   output logic [dps_pkg::WordW-1:0]     rsp_tdata
);

   import dps_pkg::*;

   localparam int TabW  = $clog2(REFRESH_DEPTH);
   localparam int RingW = $clog2(RING_DEPTH);

   state_type          state_ff, state_in;
   logic [WordW-1:0]   idle_packet_ff, idle_packet_in;
   logic [WordW-1:0]   word_ff, word_in;
   logic [TabW-1:0]    sweep_pos_ff, sweep_pos_in;
   logic [TabW-1:0]    refresh_pos_ff, refresh_pos_in;
   logic [RingW-1:0]   wr_pos_ff, wr_pos_in;
   logic [RingW-1:0]   rd_pos_ff, rd_pos_in;
   logic               from_ring_ff, from_ring_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [WordW-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic [ModeW-1:0]    mode;
   logic [DecoderW-1:0] decoder_index;
   logic [TypeW-1:0]    packet_type;
   logic [WordW-1:0]    packet_word;
   logic [SlotW-1:0]    slot;
   logic                slot_ok;
   logic                accept;
   logic                rsp_free;

   logic               tab_we, tab_re;
   logic [TabW-1:0]    tab_waddr;
   logic [WordW-1:0]   tab_wdata, tab_rdata;
   logic               ring_we, ring_re;
   logic [RingW-1:0]   ring_waddr;
   logic [WordW-1:0]   ring_wdata, ring_rdata;

   function automatic logic [RingW-1:0] ring_next(input logic [RingW-1:0] p);
      logic [RingW-1:0] n;
      n = (p == RingW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   assign mode          = req_tuser[1:0];
   assign packet_type   = req_tuser[4:2];
   assign decoder_index = req_tdata[3:0];
   assign packet_word   = req_tdata[67:4];

   assign slot    = SlotW'(decoder_index) * SlotW'(SlotsPerDecoder) + SlotW'(packet_type);
   assign slot_ok = 32'(slot) < 32'(REFRESH_DEPTH);

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      idle_packet_in = csr_we ? csr_wdata : idle_packet_ff;
      word_in        = word_ff;
      sweep_pos_in   = sweep_pos_ff;
      refresh_pos_in = refresh_pos_ff;
      wr_pos_in      = wr_pos_ff;
      rd_pos_in      = rd_pos_ff;
      from_ring_in   = from_ring_ff;
      rsp_tvalid_in  = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;

      tab_we     = 1'b0;
      tab_waddr  = sweep_pos_ff;
      tab_wdata  = word_ff;
      tab_re     = 1'b0;
      ring_we    = 1'b0;
      ring_waddr = wr_pos_ff;
      ring_wdata = word_ff;
      ring_re    = 1'b0;

      case (state_ff)
         StSweep: begin
            tab_we       = 1'b1;
            sweep_pos_in = sweep_pos_ff + 1'b1;
            if (sweep_pos_ff == TabW'(REFRESH_DEPTH - 1)) begin
               sweep_pos_in = '0;
               state_in     = StIdle;
            end
         end
         StIdle: begin
            if (accept) begin
               word_in = packet_word;
               case (mode)
                  ModeAdd: begin
                     if (slot_ok) begin
                        tab_we     = 1'b1;
                        tab_waddr  = TabW'(slot);
                        tab_wdata  = packet_word;
                        ring_we    = 1'b1;
                        ring_wdata = packet_word;
                        wr_pos_in  = ring_next(wr_pos_ff);
                        state_in   = StPush;
                     end
                  end
                  ModeFill: begin
                     sweep_pos_in = '0;
                     state_in     = StSweep;
                  end
                  ModeFetch: begin
                     tab_re = 1'b1;
                     ring_re = 1'b1;
                     state_in = StFetch;
                     if (wr_pos_ff != rd_pos_ff) begin
                        from_ring_in = 1'b1;
                        rd_pos_in    = ring_next(rd_pos_ff);
                     end else begin
                        from_ring_in   = 1'b0;
                        refresh_pos_in = (refresh_pos_ff == TabW'(REFRESH_DEPTH - 1)) ?
                                         '0 : refresh_pos_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         StPush: begin
            ring_we   = 1'b1;
            wr_pos_in = ring_next(wr_pos_ff);
            state_in  = StIdle;
         end
         StFetch: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = from_ring_ff ? ring_rdata : tab_rdata;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase

      if (reset) begin
         idle_packet_in = IdlePacketReset;
         word_in        = idle_packet_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StSweep;
         sweep_pos_ff   <= '0;
         refresh_pos_ff <= '0;
         wr_pos_ff      <= '0;
         rd_pos_ff      <= '0;
         from_ring_ff   <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_pos_ff   <= sweep_pos_in;
         refresh_pos_ff <= refresh_pos_in;
         wr_pos_ff      <= wr_pos_in;
         rd_pos_ff      <= rd_pos_in;
         from_ring_ff   <= from_ring_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idle_packet_ff <= idle_packet_in;
      word_ff        <= word_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   dps_ram #(
      .DEPTH (REFRESH_DEPTH),
      .WIDTH (WordW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (tab_re),
      .rd_addr (refresh_pos_ff),
      .rd_data (tab_rdata)
   );

   dps_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (WordW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (rd_pos_ff),
      .rd_data (ring_rdata)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
